@@ rtl/sky_pkg.sv @@
// Package for the skyline atlas allocator: widths, status codes, sequencer states.
// No dependencies.
`default_nettype none
package sky_pkg;
	localparam int unsigned MaxSegDef = 64;
	localparam int unsigned DimW = 12;
	localparam int unsigned AreaW = 24;
	localparam logic [DimW-1:0] WidthRst = 12'd1024;
	localparam logic [DimW-1:0] HeightRst = 12'd512;

	typedef enum logic [1:0] {
		ST_PLACED = 2'd0,
		ST_NOROOM = 2'd1,
		ST_FULL   = 2'd2
	} status_t;

	localparam logic [0:0] RegWidth = 1'b0;
	localparam logic [0:0] RegHeight = 1'b1;

	typedef enum logic [4:0] {
		S_INIT, S_IDLE, S_CAND, S_FCHK, S_WRD, S_WCHK, S_DECIDE,
		S_SHRD, S_SHWR, S_INS,
		S_TRRD, S_TRCHK, S_RMRD, S_RMWR,
		S_MGST, S_MGLD, S_MGRD, S_MGCHK,
		S_AREA, S_OUT
	} state_t;
endpackage
`default_nettype wire

@@ rtl/sky_if.sv @@
// Valid/ready channel carrying one payload word.
// Depends on nothing; payload type is a parameter.
`default_nettype none
interface sky_if #(parameter type T = logic) ();
	logic valid;
	logic ready;
	T     data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ rtl/sky_segmem.sv @@
// Segment store: x, y, span words, one write port and one registered read port.
// Depends on sky_pkg.
`default_nettype none
module sky_segmem #(
	parameter int unsigned MaxSeg = sky_pkg::MaxSegDef,
	localparam int unsigned IdxW = $clog2(MaxSeg)
) (
	input  wire logic                 clk,
	input  wire logic                 we,
	input  wire logic [IdxW-1:0]      waddr,
	input  wire logic [3*sky_pkg::DimW-1:0] wdata,
	input  wire logic [IdxW-1:0]      raddr,
	output logic [3*sky_pkg::DimW-1:0] rdata
);
	import sky_pkg::*;
	logic [3*DimW-1:0] mem [MaxSeg];
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

@@ rtl/skyline_atlas_allocator_unit.sv @@
// Skyline bottom-left atlas allocator, top level and sequencer.
// Depends on sky_pkg, sky_if, sky_segmem.
//
// Usage: req (sink) carries one word {req_width, req_height}; rsp (source)
// returns one word {status, pos_x, pos_y, used_area} per request. Config port:
// cfg_we, cfg_idx (0 width, 1 height), cfg_wdata. Writing the width resets
// the skyline to one segment and clears used area. Write config only while idle.
// One request at a time: req.ready is high only when idle, low from acceptance
// until the result word is taken; the next word can be taken the cycle after.
// All segment accesses share one memory with one write port and one registered read port.
// A zero size request answers in the cycle after acceptance. Otherwise the fit
// scan reads each candidate and then walks the W segments that it covers; the
// insert shifts the segments from the end down to idx up by one; trim and
// merge visit segments, and each removal shifts the later segments down; then
// come the area and the result states. The cycle count per request is set by these loops.
// Reset: the init state loads segment (1,1,1022); width 1024, height 512, area 0.
// While the receiver stalls the result holds and no new word is taken.
`default_nettype none
module skyline_atlas_allocator_unit #(
	parameter int unsigned MaxSeg = sky_pkg::MaxSegDef,
	localparam int unsigned IdxW = $clog2(MaxSeg),
	localparam int unsigned CntW = $clog2(MaxSeg + 1)
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [0:0]           cfg_idx,
	input  wire logic [sky_pkg::DimW-1:0] cfg_wdata,
	sky_if.sink                       req,
	sky_if.source                     rsp
);
	import sky_pkg::*;

	localparam logic [CntW-1:0] Full = CntW'(MaxSeg);
	localparam logic [CntW-1:0] One = CntW'(1);

	state_t st_q, st_d;
	logic [DimW-1:0] aw_q, ah_q;
	logic [CntW-1:0] cnt_q;
	logic [AreaW-1:0] area_q;
	logic [DimW-1:0] w_q, h_q;
	logic [CntW-1:0] c_q, j_q, k_q;
	logic [DimW-1:0] cx_q, cspan_q, y_q;
	logic [DimW:0] cov_q;
	logic found_q;
	logic [DimW:0] btop_q;
	logic [DimW-1:0] bspan_q, px_q, py_q;
	logic [CntW-1:0] bidx_q;
	logic [DimW-1:0] ex_q, ey_q, es_q;
	logic [DimW:0] edge_q;
	logic rmode_q;
	status_t ostat_q;
	logic [DimW-1:0] ox_q, oy_q;
	logic [AreaW-1:0] prod_q;

	logic we;
	logic [IdxW-1:0] waddr, raddr;
	logic [3*DimW-1:0] wdata, rdata;
	logic [DimW-1:0] rx, ry, rs;
	assign {rx, ry, rs} = rdata;

	sky_segmem #(.MaxSeg(MaxSeg)) u_mem (
		.clk, .we, .waddr, .wdata, .raddr, .rdata
	);

	logic [DimW-1:0] w_in, h_in;
	assign {w_in, h_in} = req.data;
	assign req.ready = (st_q == S_IDLE);
	assign rsp.valid = (st_q == S_OUT);
	assign rsp.data = {ostat_q, ox_q, oy_q, area_q};

	logic zero_req, x_over, y_over, cov_done, better, cand_end, walk_end;
	logic edge_hit, tr_drop, rm_end, mg_end, mg_eq, full;
	logic [DimW-1:0] ymax, span_cfg, span_rst, nspan, es_sum;
	logic [DimW:0] top_c, overlap;
	logic [AreaW:0] asum;
	logic [AreaW-1:0] area_sat;

	assign zero_req = (w_in == '0) || (h_in == '0);
	assign span_cfg = (cfg_wdata >= DimW'(2)) ? cfg_wdata - DimW'(2) : '0;
	assign span_rst = (aw_q >= DimW'(2)) ? aw_q - DimW'(2) : '0;
	assign x_over = (aw_q == '0) ||
		(({1'b0, rx} + {1'b0, w_q}) > ({1'b0, aw_q} - (DimW+1)'(1)));
	assign ymax = (ry > y_q) ? ry : y_q;
	assign y_over = (ah_q == '0) ||
		(({1'b0, ymax} + {1'b0, h_q}) > ({1'b0, ah_q} - (DimW+1)'(1)));
	assign cov_done = cov_q >= {1'b0, w_q};
	assign top_c = {1'b0, y_q} + {1'b0, h_q};
	assign better = !found_q || (top_c < btop_q) ||
		((top_c == btop_q) && (cspan_q < bspan_q));
	assign cand_end = c_q >= cnt_q;
	assign walk_end = j_q >= cnt_q;
	assign edge_hit = {1'b0, rx} < edge_q;
	assign overlap = edge_q - {1'b0, rx};
	assign tr_drop = {1'b0, rs} <= overlap;
	assign nspan = DimW'({1'b0, rs} - overlap);
	assign rm_end = (k_q + One) >= cnt_q;
	assign mg_end = (j_q + One) >= cnt_q;
	assign mg_eq = (ry == ey_q);
	assign es_sum = es_q + rs;
	assign full = cnt_q >= Full;
	assign asum = {1'b0, area_q} + {1'b0, prod_q};
	assign area_sat = asum[AreaW] ? {AreaW{1'b1}} : asum[AreaW-1:0];

	always_comb begin
		st_d = st_q;
		we = 1'b0;
		waddr = '0;
		wdata = '0;
		raddr = '0;
		unique case (st_q)
			S_INIT: begin
				we = 1'b1; wdata = {DimW'(1), DimW'(1), span_rst}; st_d = S_IDLE;
			end
			S_IDLE:   if (req.valid) st_d = zero_req ? S_OUT : S_CAND;
			S_CAND:   if (cand_end) st_d = S_DECIDE;
				else begin raddr = c_q[IdxW-1:0]; st_d = S_FCHK; end
			S_FCHK:   st_d = x_over ? S_CAND : S_WRD;
			S_WRD:    if (cov_done || walk_end) st_d = S_CAND;
				else begin raddr = j_q[IdxW-1:0]; st_d = S_WCHK; end
			S_WCHK:   st_d = y_over ? S_CAND : S_WRD;
			S_DECIDE: st_d = (!found_q || full) ? S_OUT : S_SHRD;
			S_SHRD:   begin raddr = k_q[IdxW-1:0]; st_d = S_SHWR; end
			S_SHWR:   begin
				we = 1'b1; waddr = IdxW'(k_q + One); wdata = rdata;
				st_d = (k_q == bidx_q) ? S_INS : S_SHRD;
			end
			S_INS:    begin
				we = 1'b1; waddr = bidx_q[IdxW-1:0];
				wdata = {px_q, DimW'(py_q + h_q), w_q};
				st_d = S_TRRD;
			end
			S_TRRD:   if (walk_end) st_d = S_MGST;
				else begin raddr = j_q[IdxW-1:0]; st_d = S_TRCHK; end
			S_TRCHK:  if (edge_hit && tr_drop) st_d = S_RMRD;
				else begin
					if (edge_hit) begin
						we = 1'b1; waddr = j_q[IdxW-1:0];
						wdata = {edge_q[DimW-1:0], ry, nspan};
					end
					st_d = S_MGST;
				end
			S_RMRD:   if (rm_end) st_d = rmode_q ? S_MGRD : S_TRRD;
				else begin raddr = IdxW'(k_q + One); st_d = S_RMWR; end
			S_RMWR:   begin
				we = 1'b1; waddr = k_q[IdxW-1:0]; wdata = rdata; st_d = S_RMRD;
			end
			S_MGST:   begin raddr = '0; st_d = S_MGLD; end
			S_MGLD:   st_d = S_MGRD;
			S_MGRD:   if (mg_end) st_d = S_AREA;
				else begin raddr = IdxW'(j_q + One); st_d = S_MGCHK; end
			S_MGCHK:  if (mg_eq) begin
					we = 1'b1; waddr = j_q[IdxW-1:0]; wdata = {ex_q, ey_q, es_sum};
					st_d = S_RMRD;
				end else st_d = S_MGRD;
			S_AREA:   st_d = S_OUT;
			S_OUT:    if (rsp.ready) st_d = S_IDLE;
			default:  st_d = S_IDLE;
		endcase
		if (cfg_we && cfg_idx == RegWidth) begin
			we = 1'b1; waddr = '0; wdata = {DimW'(1), DimW'(1), span_cfg};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) st_q <= S_INIT;
		else st_q <= st_d;
	end

	// configuration, segment count and running area
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			aw_q <= WidthRst;
			ah_q <= HeightRst;
			cnt_q <= One;
			area_q <= '0;
		end else if (cfg_we && cfg_idx == RegWidth) begin
			aw_q <= cfg_wdata; cnt_q <= One; area_q <= '0;
		end else begin
			if (cfg_we) ah_q <= cfg_wdata;
			if (st_q == S_INS) cnt_q <= cnt_q + One;
			else if (st_q == S_RMRD && rm_end) cnt_q <= cnt_q - One;
			if (st_q == S_AREA) area_q <= area_sat;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q <= '0; h_q <= '0;
			c_q <= '0; j_q <= '0; k_q <= '0;
			cx_q <= '0; cspan_q <= '0; y_q <= '0; cov_q <= '0;
			found_q <= 1'b0; btop_q <= '0; bspan_q <= '0;
			px_q <= '0; py_q <= '0; bidx_q <= '0;
			ex_q <= '0; ey_q <= '0; es_q <= '0; edge_q <= '0;
			rmode_q <= 1'b0;
			ostat_q <= ST_NOROOM; ox_q <= '0; oy_q <= '0;
			prod_q <= '0;
		end else begin
			unique case (st_q)
				S_IDLE: if (req.valid) begin
					w_q <= w_in; h_q <= h_in; c_q <= '0; found_q <= 1'b0;
					ostat_q <= ST_NOROOM; ox_q <= '0; oy_q <= '0;
				end
				S_FCHK: begin
					cx_q <= rx; cspan_q <= rs; y_q <= ry; cov_q <= '0; j_q <= c_q;
					if (x_over) c_q <= c_q + One;
				end
				S_WRD: if (cov_done || walk_end) begin
					if (cov_done && better) begin
						found_q <= 1'b1; btop_q <= top_c; bspan_q <= cspan_q;
						bidx_q <= c_q; px_q <= cx_q; py_q <= y_q;
					end
					c_q <= c_q + One;
				end
				S_WCHK: begin
					y_q <= ymax;
					if (y_over) c_q <= c_q + One;
					else begin
						cov_q <= cov_q + {1'b0, rs};
						j_q <= j_q + One;
					end
				end
				S_DECIDE: begin
					prod_q <= w_q * h_q;
					k_q <= cnt_q - One;
					if (found_q && full) ostat_q <= ST_FULL;
				end
				S_SHWR: k_q <= k_q - One;
				S_INS: begin
					j_q <= bidx_q + One;
					edge_q <= {1'b0, px_q} + {1'b0, w_q};
				end
				S_TRCHK: if (edge_hit && tr_drop) begin
					k_q <= j_q; rmode_q <= 1'b0;
				end
				S_RMWR: k_q <= k_q + One;
				S_MGLD: begin
					ex_q <= rx; ey_q <= ry; es_q <= rs; j_q <= '0;
				end
				S_MGCHK: if (mg_eq) begin
					es_q <= es_sum; k_q <= j_q + One; rmode_q <= 1'b1;
				end else begin
					ex_q <= rx; ey_q <= ry; es_q <= rs; j_q <= j_q + One;
				end
				S_AREA: begin
					ostat_q <= ST_PLACED; ox_q <= px_q; oy_q <= py_q;
				end
				default: ;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> !req.ready) else $error("result and request overlap");
	assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= Full && cnt_q != '0) else $error("segment count out of range");
	assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && !rsp.ready) |=> $stable(rsp.data)) else $error("result changed");
	assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> !req.ready) else $error("second word taken");
endmodule
`default_nettype wire

@@ bench/tb_skyline_atlas_allocator_unit.sv @@
// Testbench for the skyline atlas allocator: directed and random placement requests,
// checked word by word against an in-bench skyline predictor.
// Depends on sky_pkg, sky_if and the skyline_atlas_allocator_unit RTL.
`timescale 1ns / 100ps
module tb_skyline_atlas_allocator_unit;
	import sky_pkg::*;

	localparam int NumSeg = int'(MaxSegDef);
	localparam int StallLimit = 60000;
	localparam int LongHold = 400;

	typedef struct packed {
		logic [DimW-1:0] w;
		logic [DimW-1:0] h;
	} req_word_t;

	typedef struct packed {
		status_t          status;
		logic [DimW-1:0]  x;
		logic [DimW-1:0]  y;
		logic [AreaW-1:0] area;
	} rsp_word_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [0:0] cfg_idx = RegWidth;
	logic [DimW-1:0] cfg_wdata = '0;

	sky_if #(.T(req_word_t)) req_ch ();
	sky_if #(.T(rsp_word_t)) rsp_ch ();

	skyline_atlas_allocator_unit u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_wdata(cfg_wdata),
		.req(req_ch),
		.rsp(rsp_ch)
	);

	// predictor state
	logic [DimW-1:0] sky_x [NumSeg];
	logic [DimW-1:0] sky_y [NumSeg];
	logic [DimW-1:0] sky_span [NumSeg];
	int sky_count;
	logic [AreaW-1:0] area_sum;
	int atlas_w;
	int atlas_h;

	rsp_word_t placements_due [$];
	int errors = 0;
	int n_placed = 0;
	int n_noroom = 0;
	int n_full = 0;
	int n_sent = 0;
	bit hold_rsp = 1'b0;

	initial begin
		forever #10 clk = ~clk;
	end

	function automatic void sky_clear();
		for (int k = 0; k < NumSeg; k++) begin
			sky_x[k] = '0;
			sky_y[k] = '0;
			sky_span[k] = '0;
		end
		sky_x[0] = 12'd1;
		sky_y[0] = 12'd1;
		sky_span[0] = (atlas_w >= 2) ? DimW'(atlas_w - 2) : '0;
		sky_count = 1;
		area_sum = '0;
	endfunction

	function automatic int fit_top(int idx, int w, int h);
		int right;
		int bottom;
		int y;
		int left;
		int i;
		right = atlas_w - 1;
		bottom = atlas_h - 1;
		y = int'(sky_y[idx]);
		left = w;
		i = idx;
		if (int'(sky_x[idx]) + w > right)
			return -1;
		while (left > 0) begin
			if (i >= sky_count)
				return -1;
			if (int'(sky_y[i]) > y)
				y = int'(sky_y[i]);
			if (y + h > bottom)
				return -1;
			left -= int'(sky_span[i]);
			i++;
		end
		return y;
	endfunction

	function automatic void seg_drop(int i);
		for (int k = i; k < sky_count - 1; k++) begin
			sky_x[k] = sky_x[k + 1];
			sky_y[k] = sky_y[k + 1];
			sky_span[k] = sky_span[k + 1];
		end
		sky_count--;
	endfunction

	function automatic rsp_word_t place_rect(int w, int h);
		rsp_word_t r;
		bit found;
		int best_top, best_span, best_idx, px, py, y, top, i, edge_x, nspan;
		int unsigned sum;
		found = 1'b0;
		best_top = 0;
		best_span = 0;
		best_idx = 0;
		px = 0;
		py = 0;
		r.status = ST_NOROOM;
		r.x = '0;
		r.y = '0;
		r.area = area_sum;
		if (w == 0 || h == 0)
			return r;
		for (i = 0; i < sky_count; i++) begin
			y = fit_top(i, w, h);
			if (y >= 0) begin
				top = y + h;
				if (!found || top < best_top ||
						(top == best_top && int'(sky_span[i]) < best_span)) begin
					found = 1'b1;
					best_top = top;
					best_span = int'(sky_span[i]);
					best_idx = i;
					px = int'(sky_x[i]);
					py = y;
				end
			end
		end
		if (!found)
			return r;
		if (sky_count >= NumSeg) begin
			r.status = ST_FULL;
			return r;
		end
		for (i = sky_count; i > best_idx; i--) begin
			sky_x[i] = sky_x[i - 1];
			sky_y[i] = sky_y[i - 1];
			sky_span[i] = sky_span[i - 1];
		end
		sky_x[best_idx] = DimW'(px);
		sky_y[best_idx] = DimW'(py + h);
		sky_span[best_idx] = DimW'(w);
		sky_count++;
		i = best_idx + 1;
		while (i < sky_count) begin
			edge_x = int'(sky_x[i - 1]) + int'(sky_span[i - 1]);
			if (int'(sky_x[i]) < edge_x) begin
				nspan = int'(sky_span[i]) - (edge_x - int'(sky_x[i]));
				if (nspan <= 0) begin
					seg_drop(i);
				end else begin
					sky_x[i] = DimW'(edge_x);
					sky_span[i] = DimW'(nspan);
					break;
				end
			end else begin
				break;
			end
		end
		i = 0;
		while (i + 1 < sky_count) begin
			if (sky_y[i] == sky_y[i + 1]) begin
				sky_span[i] = sky_span[i] + sky_span[i + 1];
				seg_drop(i + 1);
			end else begin
				i++;
			end
		end
		sum = int'(area_sum) + w * h;
		area_sum = (sum > 32'hFFFFFF) ? 24'hFFFFFF : AreaW'(sum);
		r.status = ST_PLACED;
		r.x = DimW'(px);
		r.y = DimW'(py);
		r.area = area_sum;
		return r;
	endfunction

	task automatic send_rect(int w, int h);
		int gap;
		gap = $urandom_range(0, 14);
		if (gap > 0) begin
			req_ch.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_ch.valid = 1'b1;
		req_ch.data.w = DimW'(w);
		req_ch.data.h = DimW'(h);
		do @(posedge clk); while (!req_ch.ready);
		placements_due = {placements_due, place_rect(w, h)};
		n_sent++;
		@(negedge clk);
	endtask

	task automatic wait_drained();
		req_ch.valid = 1'b0;
		wait (placements_due.size() == 0);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(logic [0:0] idx, int val);
		wait_drained();
		cfg_we = 1'b1;
		cfg_idx = idx;
		cfg_wdata = DimW'(val);
		@(negedge clk);
		cfg_we = 1'b0;
		if (idx == RegWidth) begin
			atlas_w = val;
			sky_clear();
		end else begin
			atlas_h = val;
		end
		@(negedge clk);
	endtask

	// result checker with random stalls; a long hold is taken on request
	initial begin
		rsp_word_t exp_w;
		rsp_word_t got;
		int stall;
		rsp_ch.ready = 1'b0;
		wait (arst_n);
		@(negedge clk);
		forever begin
			if (hold_rsp) begin
				stall = LongHold;
				hold_rsp = 1'b0;
			end else begin
				stall = $urandom_range(0, 14);
			end
			if (stall > 0) begin
				rsp_ch.ready = 1'b0;
				repeat (stall) @(negedge clk);
			end
			rsp_ch.ready = 1'b1;
			do @(posedge clk); while (!rsp_ch.valid);
			got = rsp_ch.data;
			if (placements_due.size() == 0) begin
				$error("unexpected result word %h", got);
				errors++;
			end else begin
				exp_w = placements_due.pop_front();
				if (got.status !== exp_w.status) begin
					$error("status expected %0d actual %0d", exp_w.status, got.status);
					errors++;
				end
				if (got.x !== exp_w.x) begin
					$error("pos_x expected %0d actual %0d", exp_w.x, got.x);
					errors++;
				end
				if (got.y !== exp_w.y) begin
					$error("pos_y expected %0d actual %0d", exp_w.y, got.y);
					errors++;
				end
				if (got.area !== exp_w.area) begin
					$error("used_area expected %0d actual %0d", exp_w.area, got.area);
					errors++;
				end
				case (exp_w.status)
					ST_PLACED: n_placed++;
					ST_FULL:   n_full++;
					default:   n_noroom++;
				endcase
			end
			@(negedge clk);
		end
	end

	// watchdog on cycles without any accepted word
	initial begin
		int idle;
		idle = 0;
		forever begin
			@(posedge clk);
			if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
				idle = 0;
			else
				idle++;
			if (idle >= StallLimit) begin
				$display("skyline_atlas_allocator_unit test failed");
				$finish;
			end
		end
	end

	task automatic test_directed();
		send_rect(0, 5);
		send_rect(5, 0);
		send_rect(4095, 4095);
		send_rect(1022, 1);
		send_rect(1, 1);
		write_reg(RegWidth, 1024);
		send_rect(1022, 510);
		send_rect(1, 1);
		write_reg(RegWidth, 1024);
		send_rect(1, 4095);
		send_rect(100, 50);
		send_rect(200, 50);
		send_rect(100, 20);
		send_rect(1023, 1);
		write_reg(RegWidth, 4);
		write_reg(RegHeight, 4095);
		send_rect(3, 1);
		send_rect(2, 4093);
		send_rect(2, 1);
		write_reg(RegWidth, 1);
		send_rect(1, 1);
		write_reg(RegWidth, 0);
		send_rect(1, 1);
		write_reg(RegWidth, 4095);
		write_reg(RegHeight, 4);
		send_rect(4093, 2);
		send_rect(4093, 3);
		send_rect(2730, 1);
	endtask

	task automatic test_store_full();
		write_reg(RegWidth, 4095);
		write_reg(RegHeight, 4095);
		for (int k = 0; k < 90; k++)
			send_rect($urandom_range(1, 4), $urandom_range(1, 4000));
	endtask

	task automatic test_long_hold();
		write_reg(RegWidth, 300);
		write_reg(RegHeight, 300);
		wait_drained();
		hold_rsp = 1'b1;
		for (int k = 0; k < 6; k++)
			send_rect($urandom_range(1, 60), $urandom_range(1, 60));
		wait_drained();
	endtask

	task automatic test_random();
		int w_cfg, h_cfg;
		for (int ph = 0; ph < 15; ph++) begin
			w_cfg = ($urandom_range(0, 7) == 0) ? 4095 : $urandom_range(4, 300);
			h_cfg = ($urandom_range(0, 7) == 0) ? 4095 : $urandom_range(4, 300);
			write_reg(RegWidth, w_cfg);
			write_reg(RegHeight, h_cfg);
			for (int k = 0; k < 40; k++) begin
				if (k == 20 && $urandom_range(0, 1))
					write_reg(RegHeight, $urandom_range(4, 4095));
				if ($urandom_range(0, 9) == 0)
					send_rect($urandom_range(0, 4095), $urandom_range(0, 4095));
				else
					send_rect($urandom_range(1, (w_cfg / 3 > 1) ? w_cfg / 3 : 1),
						$urandom_range(1, (h_cfg / 3 > 1) ? h_cfg / 3 : 1));
			end
		end
	endtask

	initial begin
		req_ch.valid = 1'b0;
		req_ch.data = '0;
		atlas_w = int'(WidthRst);
		atlas_h = int'(HeightRst);
		sky_clear();
		repeat (2) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_directed();
		test_store_full();
		test_long_hold();
		test_random();
		wait_drained();
		repeat (50) @(negedge clk);
		$display("sent %0d requests over many atlas sizes: %0d placed, %0d no room, %0d store full",
			n_sent, n_placed, n_noroom, n_full);
		if (errors == 0)
			$display("skyline_atlas_allocator_unit test passed");
		else
			$display("skyline_atlas_allocator_unit test failed");
		$finish;
	end
endmodule

@@ files.f @@
rtl/sky_pkg.sv
rtl/sky_if.sv
rtl/sky_segmem.sv
rtl/skyline_atlas_allocator_unit.sv
bench/tb_skyline_atlas_allocator_unit.sv
